@@ design/hms_pkg.sv @@
package hms_pkg;

   localparam int unsigned TICK_W  = 6;
   localparam int unsigned HOUR_W  = 5;
   localparam int unsigned MIN_W   = 6;
   localparam int unsigned CUR_W   = 2;
   localparam int unsigned KEY_W   = 2;
   localparam int unsigned CSR_W   = 1;

   localparam logic [TICK_W-1:0] TPS_RESET    = 6'd20;
   localparam logic [TICK_W-1:0] COLON_RESET  = 6'd10;
   localparam logic [HOUR_W-1:0] HOURS_RESET  = 5'd12;
   localparam logic [HOUR_W-1:0] HOURS_WRAP   = 5'd24;
   localparam logic [MIN_W-1:0]  SIXTY_WRAP   = 6'd60;

   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_KEY  = 1'b1;

   localparam logic [CSR_W-1:0] CSR_TICKS_PER_SECOND = 1'b0;
   localparam logic [CSR_W-1:0] CSR_COLON_ON_TICKS   = 1'b1;

   typedef enum logic [KEY_W-1:0] {
      KEY_TOGGLE = 2'd0,
      KEY_LEFT   = 2'd1,
      KEY_RIGHT  = 2'd2,
      KEY_INC    = 2'd3
   } key_type;

   localparam logic [CUR_W-1:0] CUR_HOURS   = 2'd0;
   localparam logic [CUR_W-1:0] CUR_MINUTES = 2'd1;
   localparam logic [CUR_W-1:0] CUR_SECONDS = 2'd2;

   // state after an update, as the output stage needs it
   typedef struct packed {
      logic [HOUR_W-1:0] hours;
      logic [MIN_W-1:0]  minutes;
      logic [MIN_W-1:0]  seconds;
      logic              colon_on;
      logic              setting;
      logic [CUR_W-1:0]  cursor;
   } view_type;

   typedef struct packed {
      logic [2:0] tens;
      logic [3:0] ones;
   } digits_type;

   // binary 0..63 to two decimal digits
   function automatic digits_type to_digits(input logic [MIN_W-1:0] v);
      digits_type d;
      logic [MIN_W-1:0] base;
      if (v >= 6'd60) begin
         d.tens = 3'd6;
         base   = 6'd60;
      end else if (v >= 6'd50) begin
         d.tens = 3'd5;
         base   = 6'd50;
      end else if (v >= 6'd40) begin
         d.tens = 3'd4;
         base   = 6'd40;
      end else if (v >= 6'd30) begin
         d.tens = 3'd3;
         base   = 6'd30;
      end else if (v >= 6'd20) begin
         d.tens = 3'd2;
         base   = 6'd20;
      end else if (v >= 6'd10) begin
         d.tens = 3'd1;
         base   = 6'd10;
      end else begin
         d.tens = 3'd0;
         base   = 6'd0;
      end
      d.ones = 4'(v - base);
      return d;
   endfunction

endpackage

@@ design/hms_core.sv @@
module hms_core import hms_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_fire,
   input  logic              in_kind,
   input  logic [KEY_W-1:0]  in_key,
   input  logic              csr_write,
   input  logic [CSR_W-1:0]  csr_index,
   input  logic [TICK_W-1:0] csr_data,
   output view_type          view_next
);

   logic [TICK_W-1:0] tps_ff, colon_ff;
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic [HOUR_W-1:0] hours_ff, hours_in;
   logic [MIN_W-1:0]  minutes_ff, minutes_in;
   logic [MIN_W-1:0]  seconds_ff, seconds_in;
   logic              setting_ff, setting_in;
   logic [CUR_W-1:0]  cursor_ff, cursor_in;
   logic [TICK_W:0]   tick_inc;

   function automatic logic [MIN_W-1:0] inc60(input logic [MIN_W-1:0] v);
      logic [MIN_W-1:0] n;
      n = v + 1'b1;
      return (n >= SIXTY_WRAP) ? '0 : n;
   endfunction

   function automatic logic [HOUR_W-1:0] inc24(input logic [HOUR_W-1:0] v);
      logic [HOUR_W-1:0] n;
      n = v + 1'b1;
      return (n >= HOURS_WRAP) ? '0 : n;
   endfunction

   assign tick_inc = {1'b0, tick_ff} + 1'b1;

   always_comb begin
      tick_in    = tick_ff;
      hours_in   = hours_ff;
      minutes_in = minutes_ff;
      seconds_in = seconds_ff;
      setting_in = setting_ff;
      cursor_in  = cursor_ff;
      if (in_kind == KIND_TICK) begin
         if (!setting_ff) begin
            if (tick_inc >= {1'b0, tps_ff}) begin
               tick_in    = '0;
               seconds_in = inc60(seconds_ff);
               if (seconds_in == '0) begin
                  minutes_in = inc60(minutes_ff);
                  if (minutes_in == '0) begin
                     hours_in = inc24(hours_ff);
                  end
               end
            end else begin
               tick_in = tick_inc[TICK_W-1:0];
            end
         end
      end else begin
         unique case (key_type'(in_key))
            KEY_TOGGLE: begin
               setting_in = !setting_ff;
               if (!setting_ff) begin
                  cursor_in = CUR_HOURS;
               end
            end
            KEY_LEFT: begin
               if (setting_ff) begin
                  cursor_in = (cursor_ff == CUR_HOURS || cursor_ff > CUR_SECONDS) ?
                              CUR_SECONDS : cursor_ff - 1'b1;
               end
            end
            KEY_RIGHT: begin
               if (setting_ff) begin
                  cursor_in = (cursor_ff >= CUR_SECONDS) ? CUR_HOURS : cursor_ff + 1'b1;
               end
            end
            KEY_INC: begin
               if (setting_ff) begin
                  case (cursor_ff)
                     CUR_HOURS:   hours_in   = inc24(hours_ff);
                     CUR_MINUTES: minutes_in = inc60(minutes_ff);
                     CUR_SECONDS: seconds_in = inc60(seconds_ff);
                     default:     ;
                  endcase
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      view_next.hours    = hours_in;
      view_next.minutes  = minutes_in;
      view_next.seconds  = seconds_in;
      view_next.colon_on = (tick_in < colon_ff);
      view_next.setting  = setting_in;
      view_next.cursor   = cursor_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff     <= TPS_RESET;
         colon_ff   <= COLON_RESET;
         tick_ff    <= '0;
         hours_ff   <= HOURS_RESET;
         minutes_ff <= '0;
         seconds_ff <= '0;
         setting_ff <= 1'b0;
         cursor_ff  <= CUR_HOURS;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_TICKS_PER_SECOND: tps_ff   <= csr_data;
               CSR_COLON_ON_TICKS:   colon_ff <= csr_data;
               default: ;
            endcase
         end
         if (in_fire) begin
            tick_ff    <= tick_in;
            hours_ff   <= hours_in;
            minutes_ff <= minutes_in;
            seconds_ff <= seconds_in;
            setting_ff <= setting_in;
            cursor_ff  <= cursor_in;
         end
      end
   end

endmodule

@@ design/hms_out.sv @@
module hms_out import hms_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_fire,
   input  view_type         view_next,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output logic             out_busy,
   output logic [1:0]       rsp_hour_tens,
   output logic [3:0]       rsp_hour_ones,
   output logic [2:0]       rsp_minute_tens,
   output logic [3:0]       rsp_minute_ones,
   output logic [2:0]       rsp_second_tens,
   output logic [3:0]       rsp_second_ones,
   output logic             rsp_colon_on,
   output logic             rsp_in_set_mode,
   output logic [CUR_W-1:0] rsp_cursor_at
);

   logic       valid_ff, valid_in;
   digits_type hour_d, min_d, sec_d;
   digits_type hour_ff, min_ff, sec_ff;
   logic       colon_ff, setting_ff;
   logic [CUR_W-1:0] cursor_ff;

   assign hour_d = to_digits({1'b0, view_next.hours});
   assign min_d  = to_digits(view_next.minutes);
   assign sec_d  = to_digits(view_next.seconds);

   assign valid_in = in_fire | (valid_ff & rsp_stall);
   assign out_busy = valid_ff & rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire) begin
         hour_ff    <= hour_d;
         min_ff     <= min_d;
         sec_ff     <= sec_d;
         colon_ff   <= view_next.colon_on;
         setting_ff <= view_next.setting;
         cursor_ff  <= view_next.cursor;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_hour_tens   = hour_ff.tens[1:0];
   assign rsp_hour_ones   = hour_ff.ones;
   assign rsp_minute_tens = min_ff.tens;
   assign rsp_minute_ones = min_ff.ones;
   assign rsp_second_tens = sec_ff.tens;
   assign rsp_second_ones = sec_ff.ones;
   assign rsp_colon_on    = colon_ff;
   assign rsp_in_set_mode = setting_ff;
   assign rsp_cursor_at   = cursor_ff;

endmodule

@@ design/hms_clock_with_set_mode.sv @@
// 24-hour hh:mm:ss clock with a set mode, driven one word at a time.
// req channel: req_kind selects a timer tick (0) or a key event (1); req_key
// is toggle set mode, cursor left, cursor right or increment.
// rsp channel: one word per request, the time as six decimal digits after
// the update, the colon blink phase, the set mode flag and the cursor.
// csr channel: csr_index 0 writes ticks per second, 1 writes the colon-on
// tick count; csr_ready is always high and a write takes effect next cycle.
// A request taken at one edge shows up on rsp in the next cycle. Throughput
// is one word per cycle while no rsp word is stalled; state update and digit
// conversion sit between the state registers and the rsp register.
// When rsp_stall holds a valid word, req_stall rises in the same cycle and
// the rsp word holds; otherwise a new request is taken every cycle.
// Reset (synchronous) clears rsp_valid and sets the time to 12:00:00,
// normal mode, cursor on hours, ticks per second 20 and colon ticks 10.
module hms_clock_with_set_mode import hms_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_kind,
   input  logic [KEY_W-1:0]  req_key,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_hour_tens,
   output logic [3:0]        rsp_hour_ones,
   output logic [2:0]        rsp_minute_tens,
   output logic [3:0]        rsp_minute_ones,
   output logic [2:0]        rsp_second_tens,
   output logic [3:0]        rsp_second_ones,
   output logic              rsp_colon_on,
   output logic              rsp_in_set_mode,
   output logic [CUR_W-1:0]  rsp_cursor_at,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CSR_W-1:0]  csr_index,
   input  logic [TICK_W-1:0] csr_data
);

   logic     in_fire;
   logic     out_busy;
   view_type view_next;

   assign req_stall = out_busy;
   assign in_fire   = req_valid & ~out_busy;
   assign csr_ready = 1'b1;

   hms_core u_core (
      .clock     (clock),
      .reset     (reset),
      .in_fire   (in_fire),
      .in_kind   (req_kind),
      .in_key    (req_key),
      .csr_write (csr_valid & csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .view_next (view_next)
   );

   hms_out u_out (
      .clock           (clock),
      .reset           (reset),
      .in_fire         (in_fire),
      .view_next       (view_next),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .out_busy        (out_busy),
      .rsp_hour_tens   (rsp_hour_tens),
      .rsp_hour_ones   (rsp_hour_ones),
      .rsp_minute_tens (rsp_minute_tens),
      .rsp_minute_ones (rsp_minute_ones),
      .rsp_second_tens (rsp_second_tens),
      .rsp_second_ones (rsp_second_ones),
      .rsp_colon_on    (rsp_colon_on),
      .rsp_in_set_mode (rsp_in_set_mode),
      .rsp_cursor_at   (rsp_cursor_at)
   );

endmodule

@@ design/hms_checker.sv @@
module hms_checker import hms_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [1:0]        rsp_hour_tens,
   input logic [3:0]        rsp_hour_ones,
   input logic [2:0]        rsp_minute_tens,
   input logic [3:0]        rsp_minute_ones,
   input logic [2:0]        rsp_second_tens,
   input logic [3:0]        rsp_second_ones,
   input logic [CUR_W-1:0]  rsp_cursor_at
);

   // no word left over after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid set after reset");

   // input backs up only behind a stalled output word
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without a stalled rsp word");

   // every taken request yields a word on the next cycle
   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("taken request gave no rsp word");

   // digits and cursor stay in range
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cursor_at != 2'd3 && rsp_hour_tens != 2'd3 &&
                     rsp_hour_ones <= 4'd9 && rsp_minute_tens <= 3'd5 &&
                     rsp_minute_ones <= 4'd9 && rsp_second_tens <= 3'd5 &&
                     rsp_second_ones <= 4'd9))
      else $error("rsp word out of range");

endmodule

bind hms_clock_with_set_mode hms_checker u_checker (.*);

@@ dv/hms_clock_with_set_mode_test.sv @@
module hms_clock_with_set_mode_test import hms_pkg::*;;

   localparam int unsigned CYCLE_LIMIT = 300000;
   localparam int unsigned DRAIN_SLACK = 4;

   typedef struct packed {
      logic [1:0] hour_tens;
      logic [3:0] hour_ones;
      logic [2:0] minute_tens;
      logic [3:0] minute_ones;
      logic [2:0] second_tens;
      logic [3:0] second_ones;
      logic       colon_on;
      logic       in_set_mode;
      logic [1:0] cursor_at;
   } clock_word_type;

   typedef int field_vec_type [9];

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_kind = KIND_TICK;
   logic [KEY_W-1:0]  req_key = KEY_TOGGLE;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [1:0]        rsp_hour_tens;
   logic [3:0]        rsp_hour_ones;
   logic [2:0]        rsp_minute_tens;
   logic [3:0]        rsp_minute_ones;
   logic [2:0]        rsp_second_tens;
   logic [3:0]        rsp_second_ones;
   logic              rsp_colon_on;
   logic              rsp_in_set_mode;
   logic [CUR_W-1:0]  rsp_cursor_at;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [CSR_W-1:0]  csr_index = CSR_TICKS_PER_SECOND;
   logic [TICK_W-1:0] csr_data = '0;

   // predicted clock state and settings
   logic [TICK_W-1:0] tick_div;
   logic [HOUR_W-1:0] hh;
   logic [MIN_W-1:0]  mm;
   logic [MIN_W-1:0]  ss;
   logic              adjusting;
   logic [CUR_W-1:0]  sel_field;
   logic [TICK_W-1:0] cfg_tps;
   logic [TICK_W-1:0] cfg_colon;

   clock_word_type expected_words [$];
   int unsigned error_count = 0;
   int unsigned useful_words = 0;
   int unsigned cycle_count = 0;
   logic        quiet_stretch = 1'b0;
   string       field_names [9] = '{"hour_tens", "hour_ones", "minute_tens", "minute_ones",
                                    "second_tens", "second_ones", "colon_on", "in_set_mode",
                                    "cursor_at"};

   hms_clock_with_set_mode dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= !quiet_stretch && ($urandom_range(99) < 17);
   end

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
   endtask

   function automatic logic [MIN_W-1:0] wrap_up(input logic [MIN_W-1:0] v,
                                                input logic [MIN_W-1:0] lim);
      logic [MIN_W:0] n;
      n = {1'b0, v} + 1'b1;
      return (n >= {1'b0, lim}) ? '0 : n[MIN_W-1:0];
   endfunction

   function automatic field_vec_type field_values(input clock_word_type w);
      field_vec_type v;
      v = '{int'(w.hour_tens), int'(w.hour_ones), int'(w.minute_tens), int'(w.minute_ones),
            int'(w.second_tens), int'(w.second_ones), int'(w.colon_on), int'(w.in_set_mode),
            int'(w.cursor_at)};
      return v;
   endfunction

   task automatic reset_clock_model();
      tick_div  = '0;
      hh        = HOURS_RESET;
      mm        = '0;
      ss        = '0;
      adjusting = 1'b0;
      sel_field = CUR_HOURS;
      cfg_tps   = TPS_RESET;
      cfg_colon = COLON_RESET;
   endtask

   // update the predicted clock for one accepted word and queue the display word
   task automatic predict_display(input logic kind, input key_type key);
      clock_word_type w;
      logic [TICK_W:0] nxt;
      if (kind == KIND_TICK) begin
         if (!adjusting) begin
            nxt = {1'b0, tick_div} + 1'b1;
            if (nxt >= {1'b0, cfg_tps}) begin
               tick_div = '0;
               ss = wrap_up(ss, SIXTY_WRAP);
               if (ss == 0) begin
                  mm = wrap_up(mm, SIXTY_WRAP);
                  if (mm == 0)
                     hh = HOUR_W'(wrap_up(MIN_W'(hh), MIN_W'(HOURS_WRAP)));
               end
            end else begin
               tick_div = nxt[TICK_W-1:0];
            end
         end
      end else begin
         case (key)
            KEY_TOGGLE: begin
               if (!adjusting)
                  sel_field = CUR_HOURS;
               adjusting = !adjusting;
            end
            KEY_LEFT: begin
               if (adjusting)
                  sel_field = (sel_field == CUR_HOURS || sel_field > CUR_SECONDS) ?
                              CUR_SECONDS : sel_field - 1'b1;
            end
            KEY_RIGHT: begin
               if (adjusting)
                  sel_field = (sel_field >= CUR_SECONDS) ? CUR_HOURS : sel_field + 1'b1;
            end
            default: begin
               if (adjusting) begin
                  if (sel_field == CUR_HOURS)
                     hh = HOUR_W'(wrap_up(MIN_W'(hh), MIN_W'(HOURS_WRAP)));
                  else if (sel_field == CUR_MINUTES)
                     mm = wrap_up(mm, SIXTY_WRAP);
                  else if (sel_field == CUR_SECONDS)
                     ss = wrap_up(ss, SIXTY_WRAP);
               end
            end
         endcase
      end
      w.hour_tens   = 2'(hh / 10);
      w.hour_ones   = 4'(hh % 10);
      w.minute_tens = 3'(mm / 10);
      w.minute_ones = 4'(mm % 10);
      w.second_tens = 3'(ss / 10);
      w.second_ones = 4'(ss % 10);
      w.colon_on    = (tick_div < cfg_colon);
      w.in_set_mode = adjusting;
      w.cursor_at   = sel_field;
      expected_words.push_back(w);
   endtask

   // req_valid stays high after the word is taken; a drain lowers it, the next send only at random
   task automatic send_word(input logic kind, input key_type key);
      logic ignored;
      while (!quiet_stretch && $urandom_range(99) < 17) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind  <= kind;
      req_key   <= key;
      @(posedge clock);
      while (req_stall !== 1'b0)
         @(posedge clock);
      ignored = (kind == KIND_TICK) ? adjusting : (key != KEY_TOGGLE && !adjusting);
      predict_display(kind, key);
      if (!ignored)
         useful_words++;
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (expected_words.size() != 0)
         @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   // both registers written back to back, valid held across the two words
   task automatic apply_settings(input logic [TICK_W-1:0] tps, input logic [TICK_W-1:0] colon);
      wait_for_drain();
      csr_valid <= 1'b1;
      csr_index <= CSR_TICKS_PER_SECOND;
      csr_data  <= tps;
      @(posedge clock);
      while (csr_ready !== 1'b1)
         @(posedge clock);
      cfg_tps = tps;
      csr_index <= CSR_COLON_ON_TICKS;
      csr_data  <= colon;
      @(posedge clock);
      while (csr_ready !== 1'b1)
         @(posedge clock);
      cfg_colon = colon;
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      clock_word_type got, want;
      field_vec_type  gv, wv;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         got = '{rsp_hour_tens, rsp_hour_ones, rsp_minute_tens, rsp_minute_ones,
                 rsp_second_tens, rsp_second_ones, rsp_colon_on, rsp_in_set_mode,
                 rsp_cursor_at};
         if (expected_words.size() == 0) begin
            report_mismatch("display word with none expected");
         end else begin
            want = expected_words.pop_front();
            gv = field_values(got);
            wv = field_values(want);
            foreach (gv[i])
               if (got === 'x || gv[i] != wv[i] || $isunknown(got))
                  report_mismatch($sformatf("%s got %0d expected %0d",
                                            field_names[i], gv[i], wv[i]));
         end
      end
   end

   task automatic test_ticks_and_ignored_keys();
      send_word(KIND_TICK, KEY_INC);
      send_word(KIND_TICK, KEY_TOGGLE);
      send_word(KIND_KEY, KEY_INC);
      send_word(KIND_KEY, KEY_LEFT);
      send_word(KIND_KEY, KEY_RIGHT);
      send_word(KIND_KEY, KEY_TOGGLE);
      send_word(KIND_TICK, KEY_RIGHT);
      send_word(KIND_KEY, KEY_TOGGLE);
      send_word(KIND_TICK, KEY_LEFT);
   endtask

   task automatic test_cursor_and_set_mode();
      send_word(KIND_KEY, KEY_TOGGLE);
      send_word(KIND_KEY, KEY_LEFT);
      send_word(KIND_KEY, KEY_INC);
      send_word(KIND_KEY, KEY_RIGHT);
      send_word(KIND_KEY, KEY_INC);
      send_word(KIND_KEY, KEY_RIGHT);
      send_word(KIND_KEY, KEY_INC);
      // leave with the cursor on minutes, entering again must put it on hours
      send_word(KIND_KEY, KEY_TOGGLE);
      send_word(KIND_KEY, KEY_TOGGLE);
      send_word(KIND_KEY, KEY_TOGGLE);
   endtask

   task automatic test_divider_settings();
      apply_settings(6'd1, 6'd0);
      send_word(KIND_TICK, KEY_TOGGLE);
      send_word(KIND_TICK, KEY_INC);
      apply_settings(6'd0, 6'd63);
      send_word(KIND_TICK, KEY_LEFT);
      apply_settings(6'd20, 6'd3);
      repeat (4) send_word(KIND_TICK, KEY_RIGHT);
      // divider lowered below the running count
      apply_settings(6'd2, 6'd3);
      send_word(KIND_TICK, KEY_INC);
      apply_settings(6'd63, 6'd63);
      send_word(KIND_TICK, KEY_TOGGLE);
   endtask

   task automatic test_random_traffic();
      logic [TICK_W-1:0] tps_list [4] = '{6'd63, 6'd2, 6'd1, 6'd0};
      logic [TICK_W-1:0] colon_list [4] = '{6'd1, 6'd63, 6'd0, 6'd5};
      int unsigned start;
      int cur, target, limit, pick;
      logic [CUR_W-1:0] field;
      key_type dir;
      for (int p = 0; p < 5; p++) begin
         quiet_stretch <= (p == 0);
         if (p < 4)
            apply_settings(tps_list[p], colon_list[p]);
         else
            apply_settings(TICK_W'($urandom_range(2, 63)), TICK_W'($urandom_range(0, 63)));
         start = useful_words;
         while (useful_words - start < 400) begin
            pick = $urandom_range(99);
            if (pick < 15) begin
               repeat ($urandom_range(1, 8))
                  send_word(1'($urandom_range(1)), key_type'($urandom_range(3)));
            end else if (pick < 55) begin
               // set mode session: walk the cursor and dial fields to chosen values
               if (!adjusting)
                  send_word(KIND_KEY, KEY_TOGGLE);
               repeat ($urandom_range(1, 3)) begin
                  field = CUR_W'($urandom_range(2));
                  dir = $urandom_range(1) ? KEY_RIGHT : KEY_LEFT;
                  while (sel_field != field)
                     send_word(KIND_KEY, dir);
                  limit = (field == CUR_HOURS) ? 24 : 60;
                  cur = (field == CUR_HOURS) ? int'(hh) :
                        (field == CUR_MINUTES) ? int'(mm) : int'(ss);
                  pick = $urandom_range(9);
                  target = (pick < 5) ? limit - 1 : (pick < 7) ? 0 : $urandom_range(limit - 1);
                  repeat ((target - cur + limit) % limit) begin
                     if ($urandom_range(99) < 3)
                        send_word(KIND_TICK, key_type'($urandom_range(3)));
                     send_word(KIND_KEY, KEY_INC);
                  end
               end
               if ($urandom_range(9) != 0)
                  send_word(KIND_KEY, KEY_TOGGLE);
            end else begin
               repeat ($urandom_range(1, 150))
                  send_word(KIND_TICK, key_type'($urandom_range(3)));
            end
         end
      end
      quiet_stretch <= 1'b0;
   endtask

   initial begin
      reset_clock_model();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_ticks_and_ignored_keys();
      test_cursor_and_set_mode();
      test_divider_settings();
      test_random_traffic();
      wait_for_drain();
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
